[sv/lifeage_pkg.sv]
// ---------------------------------------------------------------------------
// lifeage_pkg
// Shared constants, codes and cell update rule for the aging life automaton.
// ---------------------------------------------------------------------------
package lifeage_pkg;

   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;
   localparam int DEPTH    = MAX_ROWS * MAX_COLS;

   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CPY_W  = $clog2(DEPTH + 1);
   localparam int DIM_W  = 7;
   localparam int CSR_W  = 7;
   localparam int IDX_W  = 2;
   localparam int CELL_W = 4;
   localparam int CNT_W  = 4;

   localparam logic [CELL_W-1:0] AGE_LIMIT   = CELL_W'(10);
   localparam logic [CELL_W-1:0] TOP_AGE     = CELL_W'(9);
   localparam logic [CNT_W-1:0]  BIRTH_COUNT = CNT_W'(3);
   localparam logic [CNT_W-1:0]  KEEP_COUNT  = CNT_W'(2);

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_GEN   = 2'd1,
      FUNC_READ  = 2'd2
   } func_type;

   typedef enum logic [IDX_W-1:0] {
      CSR_ROWS  = 2'd0,
      CSR_COLS  = 2'd1,
      CSR_WRAP  = 2'd2,
      CSR_AGING = 2'd3
   } csr_idx_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
      cell_addr = ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c));
   endfunction

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CSR_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
      if (DIM_W'(v) < DIM_W'(2))
         clamp_dim = DIM_W'(2);
      else if (DIM_W'(v) > hi)
         clamp_dim = hi;
      else
         clamp_dim = DIM_W'(v);
   endfunction

   function automatic logic [CELL_W-1:0] next_cell(input logic [CELL_W-1:0] cur,
                                                  input logic aging,
                                                  input logic [CNT_W-1:0] n);
      logic [CELL_W-1:0] aged;
      aged = cur;
      if (aging && cur != '0) begin
         aged = cur + CELL_W'(1);
         if (aged >= AGE_LIMIT)
            aged = '0;
      end
      if (aged != '0)
         next_cell = (n == KEEP_COUNT || n == BIRTH_COUNT) ? aged : '0;
      else
         next_cell = (n == BIRTH_COUNT) ? CELL_W'(1) : '0;
   endfunction

endpackage

[sv/life_automaton_with_aging.sv]
// ---------------------------------------------------------------------------
// life_automaton_with_aging
// B3/S23 grid store with optional aging, toroidal or clipped neighborhood.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low; every item returns
// exactly one result on rsp_valid/rsp_read_value for one cycle, and the
// receiver cannot stall it. A cell write is answered straight from ST_IDLE,
// a read or an unused code from ST_READ. A generation runs a copy sweep of
// the whole grid into the snapshot memory, one cell per cycle, then
// evaluates each cell in use, its 8 neighbor reads taken two at a time
// through the two read ports of the snapshot memory. After reset the block
// clears all DEPTH cells of the grid with busy high; configuration writes
// are taken during that time.
module life_automaton_with_aging (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_func,
   input  logic [5:0]                           req_row,
   input  logic [5:0]                           req_col,
   input  logic [3:0]                           req_cell_value,
   output logic                                 rsp_valid,
   output logic [3:0]                           rsp_read_value,
   input  logic                                 csr_we,
   input  logic [lifeage_pkg::IDX_W-1:0]        csr_index,
   input  logic [lifeage_pkg::CSR_W-1:0]        csr_wdata
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_COPY,
      ST_EVAL
   } state_type;

   localparam int ROW_W  = lifeage_pkg::ROW_W;
   localparam int COL_W  = lifeage_pkg::COL_W;
   localparam int ADDR_W = lifeage_pkg::ADDR_W;
   localparam int CPY_W  = lifeage_pkg::CPY_W;
   localparam int DIM_W  = lifeage_pkg::DIM_W;
   localparam int CELL_W = lifeage_pkg::CELL_W;
   localparam int CNT_W  = lifeage_pkg::CNT_W;

   state_type               state_ff, state_in;
   logic [ADDR_W-1:0]       clr_ff, clr_in;
   logic [CPY_W-1:0]        cpy_ff, cpy_in;
   logic                    cpw_ff, cpw_in;
   logic [ADDR_W-1:0]       cpa_ff, cpa_in;
   logic [ROW_W-1:0]        r_ff, r_in;
   logic [COL_W-1:0]        c_ff, c_in;
   logic [2:0]              k_ff, k_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [1:0]              ok_ff, ok_in;
   logic                    inside_ff, inside_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]       rsp_value_ff, rsp_value_in;
   logic [DIM_W-1:0]        rows_ff, cols_ff;
   logic                    wrap_ff, aging_ff;

   logic [CELL_W-1:0]       cs_mem [lifeage_pkg::DEPTH];
   logic [CELL_W-1:0]       cs_rdata_ff;
   logic                    cs_re, cs_we;
   logic [ADDR_W-1:0]       cs_raddr, cs_waddr;
   logic [CELL_W-1:0]       cs_wdata;

   logic [CELL_W-1:0]       sn_mem [lifeage_pkg::DEPTH];
   logic [CELL_W-1:0]       sn_rdata0_ff, sn_rdata1_ff;
   logic [ADDR_W-1:0]       sn_raddr0, sn_raddr1;

   logic [ROW_W-1:0]        rm, rp;
   logic [COL_W-1:0]        cm, cp;
   logic                    up_ok, dn_ok, lf_ok, rt_ok;
   logic                    last_row, last_col;
   logic [ROW_W-1:0]        nb_row [8];
   logic [COL_W-1:0]        nb_col [8];
   logic                    nb_ok  [8];
   logic [2:0]              j0, j1;
   logic [CNT_W-1:0]        cnt_sum;
   logic                    in_grid;
   logic [CELL_W-1:0]       wr_val;

   function automatic logic [ADDR_W-1:0] cell_addr_of_req();
      cell_addr_of_req = lifeage_pkg::cell_addr(ROW_W'(req_row), COL_W'(req_col));
   endfunction

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= DIM_W'(lifeage_pkg::MAX_ROWS);
         cols_ff  <= DIM_W'(lifeage_pkg::MAX_COLS);
         wrap_ff  <= 1'b1;
         aging_ff <= 1'b0;
      end else if (csr_we) begin
         case (lifeage_pkg::csr_idx_type'(csr_index))
            lifeage_pkg::CSR_ROWS: begin
               rows_ff <= lifeage_pkg::clamp_dim(csr_wdata, DIM_W'(lifeage_pkg::MAX_ROWS));
            end
            lifeage_pkg::CSR_COLS: begin
               cols_ff <= lifeage_pkg::clamp_dim(csr_wdata, DIM_W'(lifeage_pkg::MAX_COLS));
            end
            lifeage_pkg::CSR_WRAP:  wrap_ff  <= csr_wdata[0];
            lifeage_pkg::CSR_AGING: aging_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // neighbor addressing for the current cell
   always_comb begin
      last_row = (DIM_W'(r_ff) + DIM_W'(1)) == rows_ff;
      last_col = (DIM_W'(c_ff) + DIM_W'(1)) == cols_ff;
      rm = (r_ff == '0) ? ROW_W'(rows_ff - DIM_W'(1)) : r_ff - ROW_W'(1);
      rp = last_row ? '0 : r_ff + ROW_W'(1);
      cm = (c_ff == '0) ? COL_W'(cols_ff - DIM_W'(1)) : c_ff - COL_W'(1);
      cp = last_col ? '0 : c_ff + COL_W'(1);
      up_ok = wrap_ff || (r_ff != '0);
      dn_ok = wrap_ff || !last_row;
      lf_ok = wrap_ff || (c_ff != '0);
      rt_ok = wrap_ff || !last_col;

      nb_row[0] = rm;   nb_col[0] = cm;   nb_ok[0] = up_ok && lf_ok;
      nb_row[1] = rm;   nb_col[1] = c_ff; nb_ok[1] = up_ok;
      nb_row[2] = rm;   nb_col[2] = cp;   nb_ok[2] = up_ok && rt_ok;
      nb_row[3] = r_ff; nb_col[3] = cm;   nb_ok[3] = lf_ok;
      nb_row[4] = r_ff; nb_col[4] = cp;   nb_ok[4] = rt_ok;
      nb_row[5] = rp;   nb_col[5] = cm;   nb_ok[5] = dn_ok && lf_ok;
      nb_row[6] = rp;   nb_col[6] = c_ff; nb_ok[6] = dn_ok;
      nb_row[7] = rp;   nb_col[7] = cp;   nb_ok[7] = dn_ok && rt_ok;

      j0 = {k_ff[1:0], 1'b0};
      j1 = {k_ff[1:0], 1'b1};
      sn_raddr0 = lifeage_pkg::cell_addr(nb_row[j0], nb_col[j0]);
      sn_raddr1 = lifeage_pkg::cell_addr(nb_row[j1], nb_col[j1]);

      cnt_sum = cnt_ff
              + CNT_W'(ok_ff[0] && (sn_rdata0_ff != '0))
              + CNT_W'(ok_ff[1] && (sn_rdata1_ff != '0));
   end

   // control
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cpy_in       = cpy_ff;
      cpw_in       = 1'b0;
      cpa_in       = cpy_ff[ADDR_W-1:0];
      r_in         = r_ff;
      c_in         = c_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      ok_in        = {nb_ok[j1], nb_ok[j0]};
      inside_in    = inside_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = '0;

      cs_re    = 1'b0;
      cs_raddr = cell_addr_of_req();
      cs_we    = 1'b0;
      cs_waddr = clr_ff;
      cs_wdata = '0;

      in_grid = (7'(req_row) < 7'(lifeage_pkg::MAX_ROWS))
             && (7'(req_col) < 7'(lifeage_pkg::MAX_COLS));
      wr_val  = (req_cell_value > lifeage_pkg::TOP_AGE) ? lifeage_pkg::TOP_AGE
                                                        : req_cell_value;

      case (state_ff)
         ST_CLEAR: begin
            cs_we    = 1'b1;
            cs_waddr = clr_ff;
            clr_in   = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(lifeage_pkg::DEPTH - 1))
               state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               case (lifeage_pkg::func_type'(req_func))
                  lifeage_pkg::FUNC_WRITE: begin
                     cs_we        = in_grid;
                     cs_waddr     = cell_addr_of_req();
                     cs_wdata     = wr_val;
                     rsp_valid_in = 1'b1;
                  end
                  lifeage_pkg::FUNC_GEN: begin
                     cpy_in   = '0;
                     state_in = ST_COPY;
                  end
                  lifeage_pkg::FUNC_READ: begin
                     cs_re     = 1'b1;
                     inside_in = in_grid;
                     state_in  = ST_READ;
                  end
                  default: begin
                     inside_in = 1'b0;
                     state_in  = ST_READ;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = inside_ff ? cs_rdata_ff : '0;
            inside_in    = 1'b0;
            state_in     = ST_IDLE;
         end
         ST_COPY: begin
            cs_raddr = cpy_ff[ADDR_W-1:0];
            if (cpy_ff < CPY_W'(lifeage_pkg::DEPTH)) begin
               cs_re  = 1'b1;
               cpw_in = 1'b1;
               cpy_in = cpy_ff + CPY_W'(1);
            end else begin
               r_in     = '0;
               c_in     = '0;
               k_in     = '0;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cs_raddr = lifeage_pkg::cell_addr(r_ff, c_ff);
            cs_re    = (k_ff == 3'd0);
            cnt_in   = (k_ff == 3'd0) ? '0 : cnt_sum;
            k_in     = k_ff + 3'd1;
            if (k_ff == 3'd4) begin
               cs_we    = 1'b1;
               cs_waddr = lifeage_pkg::cell_addr(r_ff, c_ff);
               cs_wdata = lifeage_pkg::next_cell(cs_rdata_ff, aging_ff, cnt_sum);
               k_in     = '0;
               if (last_col) begin
                  c_in = '0;
                  r_in = r_ff + ROW_W'(1);
                  if (last_row) begin
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end else begin
                  c_in = c_ff + COL_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cpy_ff       <= '0;
         cpw_ff       <= 1'b0;
         k_ff         <= '0;
         inside_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cpy_ff       <= cpy_in;
         cpw_ff       <= cpw_in;
         k_ff         <= k_in;
         inside_ff    <= inside_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cpa_ff       <= cpa_in;
      r_ff         <= r_in;
      c_ff         <= c_in;
      cnt_ff       <= cnt_in;
      ok_ff        <= ok_in;
      rsp_value_ff <= rsp_value_in;
   end

   // grid memory
   always_ff @(posedge clock) begin
      if (cs_we)
         cs_mem[cs_waddr] <= cs_wdata;
      if (cs_re)
         cs_rdata_ff <= cs_mem[cs_raddr];
   end

   // snapshot memory
   always_ff @(posedge clock) begin
      if (cpw_ff)
         sn_mem[cpa_ff] <= cs_rdata_ff;
      sn_rdata0_ff <= sn_mem[sn_raddr0];
      sn_rdata1_ff <= sn_mem[sn_raddr1];
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;

endmodule
